>>> rtl/duty_cycled_particle_averager_macros.svh
// assertion helpers used by the checker file
// each macro expects clk and rst_n in the scope where it is used
`ifndef DUTY_CYCLED_PARTICLE_AVERAGER_MACROS_SVH
`define DUTY_CYCLED_PARTICLE_AVERAGER_MACROS_SVH

// same-cycle implication, disabled during reset
`define DCPA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DCPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dcpa_pkg.sv
// ----------------------------------------------------------------------------
// dcpa_pkg
// Shared types and constants for the duty-cycled particle averager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcpa_pkg;

    localparam int MassW       = 16;
    localparam int SumW        = 24;
    localparam int CountW      = 8;
    localparam int TimeW       = 32;
    localparam int MaxSamples  = 255;
    localparam int ReadingBits = 16;

    // count stops at the lesser of MaxSamples and the count range, never below one
    localparam int CountLimitI = (MaxSamples > 255) ? 255 : ((MaxSamples < 1) ? 1 : MaxSamples);
    localparam logic [CountW-1:0] CountLimit = CountW'(CountLimitI);

    localparam logic [MassW-1:0] ReadingMask =
        (ReadingBits >= MassW) ? {MassW{1'b1}} : MassW'((1 << ReadingBits) - 1);

    // one quotient bit per divider step
    localparam int DivSteps = SumW;
    localparam int StepW    = $clog2(DivSteps);

    // register indexes on the apb port
    localparam logic [1:0] RegWakeInterval = 2'd0;
    localparam logic [1:0] RegWarmupDelay  = 2'd1;
    localparam logic [1:0] RegReadWindow   = 2'd2;

    localparam logic [TimeW-1:0] WakeIntervalRst = 32'd300000;
    localparam logic [TimeW-1:0] WarmupDelayRst  = 32'd30000;
    localparam logic [TimeW-1:0] ReadWindowRst   = 32'd10000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_PUB,
        ST_SAMPLE,
        ST_OUT
    } dcpa_state_t;

    typedef struct packed {
        logic load;
        logic accum;
        logic div_start;
        logic div_step;
        logic publish;
        logic clear;
    } dcpa_lane_cmd_t;

    typedef struct packed {
        logic              out_load;
        logic              enable;
        logic              published;
        logic [CountW-1:0] count;
    } dcpa_status_t;

endpackage

`default_nettype wire

>>> rtl/dcpa_lane.sv
// ----------------------------------------------------------------------------
// dcpa_lane
// One mass channel: saturating accumulator, serial restoring divider that
// works in place on the sum, and the held average.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcpa_lane
    import dcpa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dcpa_lane_cmd_t    cmd,
    input  wire logic [MassW-1:0]  mass,
    input  wire logic [CountW-1:0] divisor,
    output logic      [MassW-1:0]  avg
);

    logic [MassW-1:0]  mass_reg;
    logic [SumW-1:0]   sum_reg;
    logic [SumW-1:0]   sum_next;
    logic [CountW-1:0] rem_reg;
    logic [CountW-1:0] rem_next;
    logic [MassW-1:0]  avg_reg;
    logic [SumW:0]     acc_wide;
    logic [CountW:0]   rem_shift;
    logic              fits;

    assign acc_wide  = {1'b0, sum_reg} + {{(SumW-MassW+1){1'b0}}, mass_reg};
    assign rem_shift = {rem_reg, sum_reg[SumW-1]};
    assign fits      = rem_shift >= {1'b0, divisor};

    always_comb
    begin
        sum_next = sum_reg;
        rem_next = rem_reg;
        if (cmd.accum)
        begin
            sum_next = acc_wide[SumW] ? {SumW{1'b1}} : acc_wide[SumW-1:0];
        end
        else if (cmd.div_start)
        begin
            rem_next = '0;
        end
        else if (cmd.div_step)
        begin
            // quotient bits shift in from the bottom as the dividend leaves the top
            sum_next = {sum_reg[SumW-2:0], fits};
            rem_next = fits ? CountW'(rem_shift - {1'b0, divisor}) : rem_shift[CountW-1:0];
        end
        else if (cmd.publish || cmd.clear)
        begin
            sum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            avg_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            if (cmd.publish)
            begin
                avg_reg <= sum_reg[MassW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (cmd.load)
        begin
            mass_reg <= mass & ReadingMask;
        end
    end

    assign avg = avg_reg;

endmodule

`default_nettype wire

>>> rtl/dcpa_ctrl.sv
// ----------------------------------------------------------------------------
// dcpa_ctrl
// Wake and window timing, sample count and the sequence that drives the
// three lanes through accumulate, divide and publish.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcpa_ctrl
    import dcpa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [TimeW-1:0] now_ms,
    input  wire logic             first_tick,
    input  wire logic             reading_valid,
    input  wire logic [TimeW-1:0] wake_interval_ms,
    input  wire logic [TimeW-1:0] warmup_delay_ms,
    input  wire logic [TimeW-1:0] read_window_ms,
    input  wire logic             out_free,
    output dcpa_lane_cmd_t        lane_cmd,
    output dcpa_status_t          status
);

    dcpa_state_t       state_reg;
    dcpa_state_t       state_next;
    logic [TimeW-1:0]  now_reg;
    logic              first_reg;
    logic              valid_reg;
    logic [TimeW-1:0]  wake_time_reg;
    logic              done_reg;
    logic              enable_reg;
    logic [CountW-1:0] count_reg;
    logic [StepW-1:0]  step_reg;
    logic              published_reg;

    logic [TimeW-1:0]  elapsed;
    logic [TimeW:0]    window_end;
    logic              wake;
    logic              close;
    logic              take;
    logic              accept;
    logic              do_wake;
    logic              do_close;
    logic              out_load;

    assign elapsed    = now_reg - wake_time_reg;
    assign window_end = {1'b0, warmup_delay_ms} + {1'b0, read_window_ms};
    assign wake       = (elapsed >= wake_interval_ms) || first_reg;
    assign close      = ({1'b0, elapsed} >= window_end) && !done_reg;
    // in the sample state the wake time is already updated for this tick
    assign take       = valid_reg && (elapsed >= warmup_delay_ms)
                        && ({1'b0, elapsed} < window_end) && (count_reg < CountLimit);
    assign accept     = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!wake && close && (count_reg != '0))
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_SAMPLE;
                end
            end
            ST_DIV:
            begin
                if (step_reg == StepW'(DivSteps - 1))
                begin
                    state_next = ST_PUB;
                end
            end
            ST_PUB:
            begin
                state_next = ST_SAMPLE;
            end
            ST_SAMPLE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready           = 1'b0;
        do_wake            = 1'b0;
        do_close           = 1'b0;
        lane_cmd           = '0;
        out_load           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                lane_cmd.load = in_valid;
            end
            ST_EVAL:
            begin
                do_wake            = wake;
                do_close           = !wake && close;
                lane_cmd.div_start = do_close && (count_reg != '0);
                lane_cmd.clear     = do_close && (count_reg == '0);
            end
            ST_DIV:
            begin
                lane_cmd.div_step = 1'b1;
            end
            ST_PUB:
            begin
                lane_cmd.publish = 1'b1;
            end
            ST_SAMPLE:
            begin
                lane_cmd.accum = take;
            end
            ST_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wake_time_reg <= '0;
            done_reg      <= 1'b0;
            enable_reg    <= 1'b0;
            count_reg     <= '0;
            step_reg      <= '0;
            published_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                published_reg <= 1'b0;
            end
            if (do_wake)
            begin
                wake_time_reg <= now_reg;
                enable_reg    <= 1'b1;
                done_reg      <= 1'b0;
            end
            if (do_close)
            begin
                enable_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
            if (lane_cmd.clear || lane_cmd.publish)
            begin
                count_reg <= '0;
            end
            else if (lane_cmd.accum)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (lane_cmd.div_start)
            begin
                step_reg <= '0;
            end
            else if (lane_cmd.div_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (lane_cmd.publish)
            begin
                published_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg   <= now_ms;
            first_reg <= first_tick;
            valid_reg <= reading_valid;
        end
    end

    // out_load, enable, published, count from the top bit down
    assign status = {out_load, enable_reg, published_reg, count_reg};

endmodule

`default_nettype wire

>>> rtl/duty_cycled_particle_averager.sv
// ----------------------------------------------------------------------------
// duty_cycled_particle_averager
// Wakes a particle sensor on a fixed period, averages its readings over a
// window after warm-up and publishes the three mass averages.
// ----------------------------------------------------------------------------
// One update tick is taken at a time. On the tick that closes a window with
// samples, the three lanes run a 24-step serial division of their sums by
// the sample count in lockstep, one quotient bit per cycle. The next tick is
// accepted in the cycle after the result is loaded into the output register,
// even while that beat still waits for m_tready; a stalled output holds the
// next result back. Configuration registers sit at byte addresses 0x0 (wake
// interval), 0x4 (warm-up delay) and 0x8 (read window), all in milliseconds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module duty_cycled_particle_averager
    import dcpa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // now_ms[31:0], first_tick[32], reading_valid[33], mass_pm1[49:34],
    // mass_pm25[65:50], mass_pm10[81:66], zero fill [87:82]
    input  wire logic [87:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // sensor_enable[0], averages_updated[1], avg_pm1[17:2], avg_pm25[33:18],
    // avg_pm10[49:34], window_samples[57:50], zero fill [63:58]
    output logic      [63:0] m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [TimeW-1:0] wake_interval_reg;
    logic [TimeW-1:0] warmup_delay_reg;
    logic [TimeW-1:0] read_window_reg;
    logic             cfg_write;
    logic [1:0]       cfg_sel;

    dcpa_lane_cmd_t   lane_cmd;
    dcpa_status_t     status;
    logic             out_free;
    logic [MassW-1:0] avg_pm1;
    logic [MassW-1:0] avg_pm25;
    logic [MassW-1:0] avg_pm10;

    logic             m_tvalid_reg;
    logic [63:0]      m_tdata_reg;

    // apb register file
    assign pready    = 1'b1;
    assign cfg_sel   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_interval_reg <= WakeIntervalRst;
            warmup_delay_reg  <= WarmupDelayRst;
            read_window_reg   <= ReadWindowRst;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                RegWakeInterval: wake_interval_reg <= pwdata;
                RegWarmupDelay:  warmup_delay_reg  <= pwdata;
                RegReadWindow:   read_window_reg   <= pwdata;
                default:         wake_interval_reg <= wake_interval_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            RegWakeInterval: prdata = wake_interval_reg;
            RegWarmupDelay:  prdata = warmup_delay_reg;
            RegReadWindow:   prdata = read_window_reg;
            default:         prdata = '0;
        endcase
    end

    dcpa_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .now_ms           (s_tdata[31:0]),
        .first_tick       (s_tdata[32]),
        .reading_valid    (s_tdata[33]),
        .wake_interval_ms (wake_interval_reg),
        .warmup_delay_ms  (warmup_delay_reg),
        .read_window_ms   (read_window_reg),
        .out_free         (out_free),
        .lane_cmd         (lane_cmd),
        .status           (status)
    );

    dcpa_lane u_lane_pm1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (lane_cmd),
        .mass    (s_tdata[49:34]),
        .divisor (status.count),
        .avg     (avg_pm1)
    );

    dcpa_lane u_lane_pm25 (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (lane_cmd),
        .mass    (s_tdata[65:50]),
        .divisor (status.count),
        .avg     (avg_pm25)
    );

    dcpa_lane u_lane_pm10 (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (lane_cmd),
        .mass    (s_tdata[81:66]),
        .divisor (status.count),
        .avg     (avg_pm10)
    );

    // merge lanes and control status into the output beat
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (status.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.out_load)
        begin
            m_tdata_reg <= {6'd0, status.count, avg_pm10, avg_pm25, avg_pm1,
                            status.published, status.enable};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> rtl/dcpa_checker.sv
// ----------------------------------------------------------------------------
// dcpa_checker
// Port-level checks for the duty-cycled particle averager, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "duty_cycled_particle_averager_macros.svh"

module dcpa_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    // a stalled result beat keeps its payload
    `DCPA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result beat changed")

    // publishing only happens when the window closes, which drops the enable
    `DCPA_ASSERT_SAME(a_pub_sleep, m_tvalid && m_tdata[1], !m_tdata[0], "averages published with sensor enabled")

    // the count is cleared on publish and no reading fits past the window end
    `DCPA_ASSERT_SAME(a_pub_count, m_tvalid && m_tdata[1], m_tdata[57:50] == 8'd0, "sample count not cleared on publish")

    // one tick at a time: busy right after a beat is taken
    `DCPA_ASSERT_NEXT(a_in_busy, s_tvalid && s_tready, !s_tready, "input taken while a tick is in progress")

endmodule

bind duty_cycled_particle_averager dcpa_checker u_dcpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> tb/tb_duty_cycled_particle_averager.sv
// ----------------------------------------------------------------------------
// tb_duty_cycled_particle_averager
// Drives update ticks into the averager over the stream port and programs the
// timing registers over apb. Each result beat is checked field by field against
// a local model of the wake, warm-up and sampling window behavior or against pinned values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_duty_cycled_particle_averager
    import dcpa_pkg::*;
();

    localparam int CycleLimit = 400000;
    localparam int DirRows    = 32;

    // field order from the msb down, so a plain cast matches the port packing
    typedef struct packed {
        logic [15:0] pm10;
        logic [15:0] pm25;
        logic [15:0] pm1;
        logic        reading_valid;
        logic        first_tick;
        logic [31:0] now_ms;
    } update_tick_t;

    typedef struct packed {
        logic [7:0]  window_samples;
        logic [15:0] avg_pm10;
        logic [15:0] avg_pm25;
        logic [15:0] avg_pm1;
        logic        averages_updated;
        logic        sensor_enable;
    } averager_out_t;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    typedef struct {
        row_kind_t     kind;
        logic [1:0]    reg_idx;
        logic [31:0]   reg_val;
        update_tick_t  tick;
        bit            pinned;
        averager_out_t pinned_out;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // model configuration
    logic [31:0] cfg_wake_interval = WakeIntervalRst;
    logic [31:0] cfg_warmup = WarmupDelayRst;
    logic [31:0] cfg_window = ReadWindowRst;

    // model state
    logic [31:0] av_wake_time = '0;
    logic        av_window_done = 1'b0;
    logic        av_enable = 1'b0;
    logic [23:0] av_sum [3] = '{default: '0};
    logic [7:0]  av_count = '0;
    logic [15:0] av_held [3] = '{default: '0};

    averager_out_t due_results [$];
    dir_row_t      directed_rows [DirRows];
    int            n_rows = 0;
    int            mismatches = 0;
    int            src_idle_pct = 0;
    int            sink_stall_pct = 0;
    int            cycle_count = 0;
    logic [31:0]   clock_ms = '0;

    duty_cycled_particle_averager u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [23:0] add_clamped(logic [23:0] acc, logic [15:0] v);
        logic [24:0] s;
        s = {1'b0, acc} + {9'd0, v};
        return s[24] ? 24'hFF_FFFF : s[23:0];
    endfunction

    function automatic averager_out_t advance_averager(update_tick_t t);
        logic [31:0]   elapsed;
        logic [32:0]   window_end;
        logic [15:0]   mass [3];
        logic          published;
        averager_out_t r;
        window_end = {1'b0, cfg_warmup} + {1'b0, cfg_window};
        published = 1'b0;
        mass[0] = t.pm1 & ReadingMask;
        mass[1] = t.pm25 & ReadingMask;
        mass[2] = t.pm10 & ReadingMask;
        elapsed = t.now_ms - av_wake_time;
        // a wake tick skips the window-end test
        if (elapsed >= cfg_wake_interval || t.first_tick)
        begin
            av_enable = 1'b1;
            av_wake_time = t.now_ms;
            av_window_done = 1'b0;
        end
        else if ({1'b0, elapsed} >= window_end && !av_window_done)
        begin
            av_enable = 1'b0;
            av_window_done = 1'b1;
            if (av_count != 0)
            begin
                for (int i = 0; i < 3; i++)
                    av_held[i] = 16'(av_sum[i] / {16'd0, av_count});
                published = 1'b1;
            end
            av_sum = '{default: '0};
            av_count = '0;
        end
        // readings are judged against the wake time after this tick
        elapsed = t.now_ms - av_wake_time;
        if (t.reading_valid && elapsed >= cfg_warmup && {1'b0, elapsed} < window_end
            && av_count < CountLimit)
        begin
            av_count = av_count + 8'd1;
            for (int i = 0; i < 3; i++)
                av_sum[i] = add_clamped(av_sum[i], mass[i]);
        end
        r.sensor_enable = av_enable;
        r.averages_updated = published;
        r.avg_pm1 = av_held[0];
        r.avg_pm25 = av_held[1];
        r.avg_pm10 = av_held[2];
        r.window_samples = av_count;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
        mismatches++;
    endtask

    task automatic drive_tick(input update_tick_t t, input bit pinned,
                              input averager_out_t pinned_out);
        averager_out_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, t};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = advance_averager(t);
        due_results.push_back(pinned ? pinned_out : predicted);
    endtask

    // every tick yields a beat, so an empty queue means the block is idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            RegWakeInterval: cfg_wake_interval = val;
            RegWarmupDelay:  cfg_warmup = val;
            RegReadWindow:   cfg_window = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] wake, input logic [31:0] warm,
                             input logic [31:0] win);
        settle();
        apb_write(RegWakeInterval, wake);
        apb_write(RegWarmupDelay, warm);
        apb_write(RegReadWindow, win);
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SRC:  begin src_idle_pct = 45; sink_stall_pct = 0;  end
            IDLE_SINK: begin src_idle_pct = 0;  sink_stall_pct = 45; end
            default:   begin src_idle_pct = 25; sink_stall_pct = 25; end
        endcase
    endtask

    function automatic logic [15:0] pick_mass();
        case ($urandom_range(9))
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // random ticks with a forward-running clock, or scattered timestamps
    task automatic run_traffic(input idle_mode_t mode, input int n, input int step_max,
                               input int valid_pct, input bit scatter);
        update_tick_t t;
        set_idle(mode);
        repeat (n)
        begin
            if (scatter)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + $urandom_range(step_max);
            t.now_ms = clock_ms;
            t.first_tick = ($urandom_range(99) < 2);
            t.reading_valid = ($urandom_range(99) < valid_pct);
            t.pm1 = pick_mass();
            t.pm25 = pick_mass();
            t.pm10 = pick_mass();
            drive_tick(t, 1'b0, '0);
        end
    endtask

    task automatic add_tick(input logic [31:0] now, input logic first, input logic valid,
                            input logic [15:0] m1, input logic [15:0] m25,
                            input logic [15:0] m10);
        directed_rows[n_rows].kind = ROW_TICK;
        directed_rows[n_rows].tick = {m10, m25, m1, valid, first, now};
        directed_rows[n_rows].pinned = 1'b0;
        n_rows++;
    endtask

    task automatic pin_last(input logic en, input logic upd, input logic [15:0] a1,
                            input logic [15:0] a25, input logic [15:0] a10,
                            input logic [7:0] n);
        directed_rows[n_rows-1].pinned = 1'b1;
        directed_rows[n_rows-1].pinned_out = {n, a10, a25, a1, upd, en};
    endtask

    task automatic add_cfg(input logic [1:0] idx, input logic [31:0] val);
        directed_rows[n_rows].kind = ROW_CFG;
        directed_rows[n_rows].reg_idx = idx;
        directed_rows[n_rows].reg_val = val;
        directed_rows[n_rows].pinned = 1'b0;
        n_rows++;
    endtask

    always @(posedge clk)
    begin : result_check
        averager_out_t got_out;
        averager_out_t want_out;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got_out = averager_out_t'(m_tdata[57:0]);
                if (due_results.size() == 0)
                    note_mismatch("beat with nothing due", m_tdata[31:0], 32'd0);
                else
                begin
                    want_out = due_results.pop_front();
                    if (got_out.sensor_enable !== want_out.sensor_enable)
                        note_mismatch("sensor_enable", 32'(got_out.sensor_enable),
                                      32'(want_out.sensor_enable));
                    if (got_out.averages_updated !== want_out.averages_updated)
                        note_mismatch("averages_updated", 32'(got_out.averages_updated),
                                      32'(want_out.averages_updated));
                    if (got_out.avg_pm1 !== want_out.avg_pm1)
                        note_mismatch("avg_pm1", 32'(got_out.avg_pm1), 32'(want_out.avg_pm1));
                    if (got_out.avg_pm25 !== want_out.avg_pm25)
                        note_mismatch("avg_pm25", 32'(got_out.avg_pm25),
                                      32'(want_out.avg_pm25));
                    if (got_out.avg_pm10 !== want_out.avg_pm10)
                        note_mismatch("avg_pm10", 32'(got_out.avg_pm10),
                                      32'(want_out.avg_pm10));
                    if (got_out.window_samples !== want_out.window_samples)
                        note_mismatch("window_samples", 32'(got_out.window_samples),
                                      32'(want_out.window_samples));
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        // reset values: a plain tick, a forced wake, a window with two samples
        add_tick(32'd0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
        pin_last(1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 8'd0);
        add_tick(32'd100, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        pin_last(1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 8'd0);
        add_tick(32'd30100, 1'b0, 1'b1, 16'hFFFF, 16'h0000, 16'h0001);
        pin_last(1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 8'd1);
        add_tick(32'd40099, 1'b0, 1'b1, 16'h0001, 16'hFFFF, 16'h0000);
        pin_last(1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 8'd2);
        add_tick(32'd40100, 1'b0, 1'b1, 16'd5, 16'd5, 16'd5);
        pin_last(1'b0, 1'b1, 16'd32768, 16'd32767, 16'd0, 8'd0);
        add_tick(32'd50000, 1'b0, 1'b1, 16'd7, 16'd7, 16'd7);
        pin_last(1'b0, 1'b0, 16'd32768, 16'd32767, 16'd0, 8'd0);
        add_tick(32'd300099, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
        pin_last(1'b0, 1'b0, 16'd32768, 16'd32767, 16'd0, 8'd0);
        add_tick(32'd300100, 1'b0, 1'b1, 16'd9, 16'd9, 16'd9);
        pin_last(1'b1, 1'b0, 16'd32768, 16'd32767, 16'd0, 8'd0);
        // window with no samples: enable drops, averages kept
        add_tick(32'd340100, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
        pin_last(1'b0, 1'b0, 16'd32768, 16'd32767, 16'd0, 8'd0);
        // zero warm-up takes a reading on the wake tick, across the time wrap
        add_cfg(RegWarmupDelay, 32'd0);
        add_cfg(RegReadWindow, 32'd5);
        add_cfg(RegWakeInterval, 32'hFFFF_FFFF);
        add_tick(32'hFFFF_FFFE, 1'b1, 1'b1, 16'hAAAA, 16'h5555, 16'h1234);
        pin_last(1'b1, 1'b0, 16'd32768, 16'd32767, 16'd0, 8'd1);
        add_tick(32'd2, 1'b0, 1'b1, 16'h5555, 16'hAAAA, 16'hFFFF);
        add_tick(32'd3, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
        // zero wake interval: every tick wakes
        add_cfg(RegWakeInterval, 32'd0);
        add_tick(32'd1000, 1'b0, 1'b1, 16'h8000, 16'h0001, 16'hFFFF);
        add_tick(32'd1000, 1'b0, 1'b1, 16'h7FFF, 16'hFFFE, 16'h0000);
        // zero read window: nothing is ever sampled
        add_cfg(RegReadWindow, 32'd0);
        add_tick(32'd2000, 1'b0, 1'b1, 16'd3, 16'd3, 16'd3);
        // window end past 2^32: the window never closes
        add_cfg(RegWakeInterval, 32'd100);
        add_cfg(RegWarmupDelay, 32'hFFFF_FFFF);
        add_cfg(RegReadWindow, 32'hFFFF_FFFF);
        add_tick(32'd5000, 1'b1, 1'b1, 16'd11, 16'd12, 16'd13);
        add_tick(32'd5050, 1'b0, 1'b1, 16'd14, 16'd15, 16'd16);
        add_tick(32'd5100, 1'b0, 1'b1, 16'd17, 16'd18, 16'd19);
        add_tick(32'd5199, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(IDLE_NONE);
        for (int i = 0; i < n_rows; i++)
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                settle();
                apb_write(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
                drive_tick(directed_rows[i].tick, directed_rows[i].pinned,
                           directed_rows[i].pinned_out);
        end

        configure(32'd200, 32'd40, 32'd80);
        clock_ms = $urandom;
        run_traffic(IDLE_NONE, 80, 12, 70, 1'b0);

        // long window with dense readings runs the count into its limit
        configure(32'd2000, 32'd0, 32'd1500);
        run_traffic(IDLE_SRC, 300, 3, 95, 1'b0);
        run_traffic(IDLE_SINK, 60, 40, 50, 1'b0);

        configure($urandom_range(300, 1), $urandom_range(100), $urandom_range(150, 1));
        run_traffic(IDLE_BOTH, 80, 10, 60, 1'b0);

        configure(32'hFFFF_FFFF, $urandom, $urandom);
        run_traffic(IDLE_SRC, 50, 1, 50, 1'b1);

        configure(32'd1, 32'd0, 32'd1);
        run_traffic(IDLE_SINK, 50, 2, 80, 1'b0);

        configure(32'd150, 32'd20, 32'd60);
        clock_ms = 32'hFFFF_FF00;
        run_traffic(IDLE_BOTH, 60, 8, 70, 1'b0);

        configure(32'd300, 32'd0, 32'hFFFF_FFFF);
        run_traffic(IDLE_NONE, 50, 10, 90, 1'b0);

        configure(WakeIntervalRst, WarmupDelayRst, ReadWindowRst);
        run_traffic(IDLE_BOTH, 60, 4000, 60, 1'b0);

        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
